[rtl/core/tccw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cursor writer
// Screen geometry, field widths, control codes and the result beat type.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;

  // field widths
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT_CHAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_COLOR = 2'd2;

  // configuration register indexes
  localparam logic REG_DEFAULT_COLOR = 1'b0;
  localparam logic REG_ERASE_COLOR   = 1'b1;

  // control and fill characters
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BLANK   = 8'h20;

  // tab stops every eight columns
  localparam int unsigned TAB_STEP = 8;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RST = 8'd7;
  localparam logic [BYTE_W-1:0] ERASE_COLOR_RST   = 8'd240;

  // one result beat
  typedef struct packed {
    logic              write_valid;
    logic [IDX_W-1:0]  cell_index;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } result_t;

endpackage

[rtl/core/text_console_cursor_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer: cursor and cell write generator for a text screen
// Tracks cursor and current color; turns each operation into one result beat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): op, char_code, color_value. A beat
//   is taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one result beat per input beat,
//   in order: write_valid, cell_index, cell_char, cell_attr and the cursor
//   position after the operation.
//   Config port: cfg_write with cfg_index (0 default color, 1 erase color)
//   and cfg_data, written at any edge with cfg_write high.
// Timing
//   The cursor and color update is done in the cycle a beat is taken; the
//   result is registered in the output register, or in the skid register
//   while the output beat is held. One beat per cycle while out_stall is low.
// Reset (rst, synchronous, active high)
//   Cursor goes to row 0 column 0, current color and default color to 7,
//   erase color to 240; output and skid registers are emptied.
// Stall
//   A two-entry output stage (output register plus skid register) keeps
//   taking beats while a result waits; in_stall rises once both are full.
// ----------------------------------------------------------------------------
module text_console_cursor_writer (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [tccw_pkg::BYTE_W-1:0]          cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tccw_pkg::OP_W-1:0]            op,
  input  logic [tccw_pkg::BYTE_W-1:0]          char_code,
  input  logic [tccw_pkg::BYTE_W-1:0]          color_value,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 write_valid,
  output logic [tccw_pkg::IDX_W-1:0]           cell_index,
  output logic [tccw_pkg::BYTE_W-1:0]          cell_char,
  output logic [tccw_pkg::BYTE_W-1:0]          cell_attr,
  output logic [tccw_pkg::COL_W-1:0]           cursor_col,
  output logic [tccw_pkg::ROW_W-1:0]           cursor_row
);

  localparam int unsigned COL_X_W = tccw_pkg::COL_W + 1;
  localparam int unsigned ROW_X_W = tccw_pkg::ROW_W + 1;

  // configuration registers
  logic [tccw_pkg::BYTE_W-1:0] default_color;
  logic [tccw_pkg::BYTE_W-1:0] erase_color;

  // cursor state
  logic [tccw_pkg::COL_W-1:0]  col_pos, col_pos_next;
  logic [tccw_pkg::ROW_W-1:0]  row_pos, row_pos_next;
  logic [tccw_pkg::BYTE_W-1:0] active_color, active_color_next;

  // output stage
  tccw_pkg::result_t out_beat;
  tccw_pkg::result_t skid_beat;
  logic              skid_valid;
  tccw_pkg::result_t result_next;

  logic in_take;
  logic out_free;

  // intermediate cursor values; col_x, row_x and col_tab are one bit wider to see the wrap
  logic [COL_X_W-1:0]  col_x;
  logic [ROW_X_W-1:0]  row_x;
  logic [COL_X_W-1:0]  col_tab;
  logic [tccw_pkg::COL_W-1:0] col_back;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  assign col_tab  = (COL_X_W'(col_pos) + COL_X_W'(tccw_pkg::TAB_STEP))
                    & ~COL_X_W'(tccw_pkg::TAB_STEP - 1);
  assign col_back = col_pos - tccw_pkg::COL_W'(1);

  // cursor update and result for one beat
  always_comb begin
    col_pos_next      = col_pos;
    row_pos_next      = row_pos;
    active_color_next = active_color;
    result_next       = '0;
    col_x             = COL_X_W'(col_pos);
    row_x             = ROW_X_W'(row_pos);
    case (op)
      tccw_pkg::OP_PUT_CHAR: begin
        case (char_code)
          tccw_pkg::CH_NEWLINE: begin
            col_x = '0;
            row_x = ROW_X_W'(row_pos) + ROW_X_W'(1);
          end
          tccw_pkg::CH_RETURN: begin
            col_x = '0;
          end
          tccw_pkg::CH_TAB: begin
            col_x = col_tab;
          end
          default: begin
            result_next.write_valid = 1'b1;
            result_next.cell_index  =
              tccw_pkg::IDX_W'(row_pos) * tccw_pkg::IDX_W'(tccw_pkg::COLUMNS)
              + tccw_pkg::IDX_W'(col_pos);
            result_next.cell_char   = char_code;
            result_next.cell_attr   = active_color;
            col_x = COL_X_W'(col_pos) + COL_X_W'(1);
          end
        endcase
        // line wrap, then screen wrap
        if (col_x >= COL_X_W'(tccw_pkg::COLUMNS)) begin
          col_x = '0;
          row_x = row_x + ROW_X_W'(1);
        end
        if (row_x >= ROW_X_W'(tccw_pkg::ROWS)) begin
          row_x = '0;
        end
        col_pos_next = col_x[tccw_pkg::COL_W-1:0];
        row_pos_next = row_x[tccw_pkg::ROW_W-1:0];
      end
      tccw_pkg::OP_BACKSPACE: begin
        if (col_pos != '0) begin
          col_pos_next            = col_back;
          result_next.write_valid = 1'b1;
          result_next.cell_index  =
            tccw_pkg::IDX_W'(row_pos) * tccw_pkg::IDX_W'(tccw_pkg::COLUMNS)
            + tccw_pkg::IDX_W'(col_back);
          result_next.cell_char   = tccw_pkg::CH_BLANK;
          result_next.cell_attr   = erase_color;
          active_color_next       = default_color;
        end
      end
      tccw_pkg::OP_SET_COLOR: begin
        active_color_next = color_value;
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase
    result_next.cursor_col = col_pos_next;
    result_next.cursor_row = row_pos_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= tccw_pkg::DEFAULT_COLOR_RST;
      erase_color   <= tccw_pkg::ERASE_COLOR_RST;
    end else if (cfg_write) begin
      if (cfg_index == tccw_pkg::REG_DEFAULT_COLOR) begin
        default_color <= cfg_data;
      end
      if (cfg_index == tccw_pkg::REG_ERASE_COLOR) begin
        erase_color <= cfg_data;
      end
    end
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos      <= '0;
      row_pos      <= '0;
      active_color <= tccw_pkg::DEFAULT_COLOR_RST;
    end else if (in_take) begin
      col_pos      <= col_pos_next;
      row_pos      <= row_pos_next;
      active_color <= active_color_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_beat <= skid_beat;
      end
    end else if (in_take) begin
      if (out_free) begin
        out_beat <= result_next;
      end else begin
        skid_beat <= result_next;
      end
    end
  end

  assign write_valid = out_beat.write_valid;
  assign cell_index  = out_beat.cell_index;
  assign cell_char   = out_beat.cell_char;
  assign cell_attr   = out_beat.cell_attr;
  assign cursor_col  = out_beat.cursor_col;
  assign cursor_row  = out_beat.cursor_row;

`ifndef SYNTHESIS
  // skid register is only filled behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with output register empty");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (col_pos < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)) &&
    (row_pos < tccw_pkg::ROW_W'(tccw_pkg::ROWS)))
    else $error("cursor outside the screen");

  // written cell lies inside the screen
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |->
      (cell_index < tccw_pkg::IDX_W'(tccw_pkg::COLUMNS * tccw_pkg::ROWS)))
    else $error("cell index outside the screen");

  // beats without a write carry zero cell fields
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_valid) |->
      (cell_index == '0 && cell_char == '0 && cell_attr == '0))
    else $error("cell fields set on a beat without a write");

  // a full output stage stalls the input on the next cycle
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_take && out_valid && out_stall && !skid_valid) |=> in_stall)
    else $error("input not stalled with output stage full");
`endif

endmodule

[tb/sv/tb_text_console_cursor_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_writer: self-checking bench for the console writer
// Drives put-character, backspace, set-color and unused-op beats through the
// valid/stall input channel. A behavioral console model predicts the result
// beats, directed rows marked typed carry their own, and the output beats are
// compared field by field in order. A short directed table runs first, then
// random phases varying register settings, sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_writer;

  localparam logic [tccw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 340;
  localparam int NUM_PHASES   = 5;

  // directed stimulus row; want is used only when typed is set
  typedef struct {
    logic [tccw_pkg::OP_W-1:0]   opc;
    logic [tccw_pkg::BYTE_W-1:0] ch;
    logic [tccw_pkg::BYTE_W-1:0] color;
    bit                          typed;
    tccw_pkg::result_t           want;
  } dir_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic                        cfg_index;
  logic [tccw_pkg::BYTE_W-1:0] cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [tccw_pkg::OP_W-1:0]   op;
  logic [tccw_pkg::BYTE_W-1:0] char_code;
  logic [tccw_pkg::BYTE_W-1:0] color_value;
  logic                        out_valid;
  logic                        out_stall;
  logic                        write_valid;
  logic [tccw_pkg::IDX_W-1:0]  cell_index;
  logic [tccw_pkg::BYTE_W-1:0] cell_char;
  logic [tccw_pkg::BYTE_W-1:0] cell_attr;
  logic [tccw_pkg::COL_W-1:0]  cursor_col;
  logic [tccw_pkg::ROW_W-1:0]  cursor_row;

  // console model state and its copy of the registers
  logic [tccw_pkg::COL_W-1:0]  cur_col;
  logic [tccw_pkg::ROW_W-1:0]  cur_row;
  logic [tccw_pkg::BYTE_W-1:0] cur_attr;
  logic [tccw_pkg::BYTE_W-1:0] dflt_attr;
  logic [tccw_pkg::BYTE_W-1:0] erase_attr;

  tccw_pkg::result_t expected_beats[$];
  dir_row_t          dir_rows[$];
  int                errors;
  int                cycles;
  int                send_idle;
  int                recv_stall;

  text_console_cursor_writer u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .char_code   (char_code),
    .color_value (color_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .write_valid (write_valid),
    .cell_index  (cell_index),
    .cell_char   (cell_char),
    .cell_attr   (cell_attr),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  function automatic tccw_pkg::result_t beat_of(input logic wv, input int idx,
                                                input int ch, input int attr,
                                                input int col, input int row);
    tccw_pkg::result_t r;
    r.write_valid = wv;
    r.cell_index  = idx[tccw_pkg::IDX_W-1:0];
    r.cell_char   = ch[tccw_pkg::BYTE_W-1:0];
    r.cell_attr   = attr[tccw_pkg::BYTE_W-1:0];
    r.cursor_col  = col[tccw_pkg::COL_W-1:0];
    r.cursor_row  = row[tccw_pkg::ROW_W-1:0];
    return r;
  endfunction

  // apply one operation to the console model and return its result beat
  function automatic tccw_pkg::result_t console_step(
      input logic [tccw_pkg::OP_W-1:0] o,
      input logic [tccw_pkg::BYTE_W-1:0] ch,
      input logic [tccw_pkg::BYTE_W-1:0] color);
    int unsigned       col;
    int unsigned       row;
    tccw_pkg::result_t r;
    col = cur_col;
    row = cur_row;
    r   = '0;
    case (o)
      tccw_pkg::OP_PUT_CHAR: begin
        if (ch == tccw_pkg::CH_NEWLINE) begin
          col = 0;
          row++;
        end else if (ch == tccw_pkg::CH_RETURN) begin
          col = 0;
        end else if (ch == tccw_pkg::CH_TAB) begin
          col = (col + tccw_pkg::TAB_STEP) & ~(tccw_pkg::TAB_STEP - 1);
        end else begin
          r.write_valid = 1'b1;
          r.cell_index  = tccw_pkg::IDX_W'(row * tccw_pkg::COLUMNS + col);
          r.cell_char   = ch;
          r.cell_attr   = cur_attr;
          col++;
        end
        // line wrap, then screen wrap with no scrolling
        if (col >= tccw_pkg::COLUMNS) begin
          col = 0;
          row++;
        end
        if (row >= tccw_pkg::ROWS) row = 0;
      end
      tccw_pkg::OP_BACKSPACE: begin
        if (col != 0) begin
          col--;
          r.write_valid = 1'b1;
          r.cell_index  = tccw_pkg::IDX_W'(row * tccw_pkg::COLUMNS + col);
          r.cell_char   = tccw_pkg::CH_BLANK;
          r.cell_attr   = erase_attr;
          cur_attr      = dflt_attr;
        end
      end
      tccw_pkg::OP_SET_COLOR: cur_attr = color;
      default: ;
    endcase
    cur_col      = col[tccw_pkg::COL_W-1:0];
    cur_row      = row[tccw_pkg::ROW_W-1:0];
    r.cursor_col = cur_col;
    r.cursor_row = cur_row;
    return r;
  endfunction

  // present one beat after random idle cycles and hold it until taken
  task automatic send_beat(input logic [tccw_pkg::OP_W-1:0] o,
                           input logic [tccw_pkg::BYTE_W-1:0] ch,
                           input logic [tccw_pkg::BYTE_W-1:0] color, input bit typed,
                           input tccw_pkg::result_t want);
    tccw_pkg::result_t predicted;
    while ((send_idle > 0) && ($urandom_range(99) < send_idle)) begin
      in_valid    = 1'b0;
      op          = tccw_pkg::OP_W'($urandom);
      char_code   = tccw_pkg::BYTE_W'($urandom);
      color_value = tccw_pkg::BYTE_W'($urandom);
      @(negedge clk);
    end
    in_valid    = 1'b1;
    op          = o;
    char_code   = ch;
    color_value = color;
    do @(posedge clk); while (in_stall);
    predicted = console_step(o, ch, color);
    expected_beats.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic idx, input logic [tccw_pkg::BYTE_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == tccw_pkg::REG_DEFAULT_COLOR) dflt_attr = val;
    else erase_attr = val;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = tccw_pkg::BYTE_W'($urandom);
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random operation mix; mostly random character bytes with some control codes
  task automatic send_random();
    int unsigned                 pick;
    logic [tccw_pkg::OP_W-1:0]   o;
    logic [tccw_pkg::BYTE_W-1:0] ch;
    logic [tccw_pkg::BYTE_W-1:0] color;
    pick  = $urandom_range(99);
    ch    = tccw_pkg::BYTE_W'($urandom);
    color = tccw_pkg::BYTE_W'($urandom);
    if (pick < 3) o = OP_UNUSED;
    else if (pick < 14) o = tccw_pkg::OP_BACKSPACE;
    else if (pick < 22) o = tccw_pkg::OP_SET_COLOR;
    else begin
      o = tccw_pkg::OP_PUT_CHAR;
      if (pick < 25) ch = tccw_pkg::CH_NEWLINE;
      else if (pick < 27) ch = tccw_pkg::CH_RETURN;
      else if (pick < 36) ch = tccw_pkg::CH_TAB;
    end
    send_beat(o, ch, color, 1'b0, '0);
  endtask

  // compare one result field
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result beat checker
  always @(posedge clk) begin
    tccw_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual index %0d col %0d row %0d",
                 $time, cell_index, cursor_col, cursor_row);
      end else begin
        want = expected_beats.pop_front();
        check_field("write_valid", want.write_valid, write_valid);
        check_field("cell_index", want.cell_index, cell_index);
        check_field("cell_char", want.cell_char, cell_char);
        check_field("cell_attr", want.cell_attr, cell_attr);
        check_field("cursor_col", want.cursor_col, cursor_col);
        check_field("cursor_row", want.cursor_row, cursor_row);
      end
    end
  end

  initial begin
    logic [tccw_pkg::BYTE_W-1:0] dflt_set[NUM_PHASES];
    logic [tccw_pkg::BYTE_W-1:0] erase_set[NUM_PHASES];
    int                          idle_set[NUM_PHASES];
    int                          stall_set[NUM_PHASES];

    errors      = 0;
    cycles      = 0;
    send_idle   = 0;
    recv_stall  = 0;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = tccw_pkg::REG_DEFAULT_COLOR;
    cfg_data    = '0;
    in_valid    = 1'b0;
    op          = tccw_pkg::OP_PUT_CHAR;
    char_code   = '0;
    color_value = '0;
    out_stall   = 1'b0;
    cur_col     = '0;
    cur_row     = '0;
    cur_attr    = tccw_pkg::DEFAULT_COLOR_RST;
    dflt_attr   = tccw_pkg::DEFAULT_COLOR_RST;
    erase_attr  = tccw_pkg::ERASE_COLOR_RST;

    // directed rows, run with the reset register values
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h41, 8'h00, 1'b1,
                         beat_of(1'b1, 0, 8'h41, 7, 1, 0)});
    dir_rows.push_back('{tccw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 1'b1,
                         beat_of(1'b1, 0, 8'h20, 240, 0, 0)});
    // backspace at column zero does nothing
    dir_rows.push_back('{tccw_pkg::OP_BACKSPACE, 8'hFF, 8'hFF, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{tccw_pkg::OP_SET_COLOR, 8'h00, 8'hFF, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h00, 8'h00, 1'b1,
                         beat_of(1'b1, 0, 8'h00, 255, 1, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'hFF, 8'h00, 1'b1,
                         beat_of(1'b1, 1, 8'hFF, 255, 2, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_TAB, 8'h00, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 8, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_TAB, 8'h00, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 16, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_RETURN, 8'h00, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_NEWLINE, 8'h00, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 1)});
    // unused op leaves everything alone
    dir_rows.push_back('{OP_UNUSED, 8'hAA, 8'h55, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{tccw_pkg::OP_SET_COLOR, 8'hFF, 8'h00, 1'b1,
                         beat_of(1'b0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_BLANK, 8'hFF, 1'b1,
                         beat_of(1'b1, 80, 8'h20, 0, 1, 1)});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h7F, 8'h00, 1'b0, '0});
    // backspace restores the default color for the next write
    dir_rows.push_back('{tccw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h0B, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h08, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_SET_COLOR, tccw_pkg::CH_NEWLINE, 8'hA5, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_NEWLINE, 8'h5A, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_TAB, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, 8'h78, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_PUT_CHAR, tccw_pkg::CH_TAB, 8'h00, 1'b0, '0});
    dir_rows.push_back('{tccw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 1'b0, '0});

    // per phase register values, idle rates and stall rates
    dflt_set  = '{8'h00, 8'hFF, tccw_pkg::BYTE_W'($urandom), tccw_pkg::DEFAULT_COLOR_RST,
                  tccw_pkg::BYTE_W'($urandom)};
    erase_set = '{8'hFF, 8'h00, tccw_pkg::BYTE_W'($urandom), tccw_pkg::ERASE_COLOR_RST,
                  tccw_pkg::BYTE_W'($urandom)};
    idle_set  = '{0, 74, 0, 17, 0};
    stall_set = '{0, 0, 74, 17, 0};

    // synchronous reset
    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].opc, dir_rows[i].ch, dir_rows[i].color, dir_rows[i].typed,
                dir_rows[i].want);
    in_valid = 1'b0;

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(tccw_pkg::REG_DEFAULT_COLOR, dflt_set[p]);
      write_reg(tccw_pkg::REG_ERASE_COLOR, erase_set[p]);
      send_idle  = idle_set[p];
      recv_stall = stall_set[p];
      repeat (PHASE_BEATS) send_random();
      in_valid = 1'b0;
    end

    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tccw_pkg.sv
rtl/core/text_console_cursor_writer.sv
tb/sv/tb_text_console_cursor_writer.sv
